// ===== src/oas_pkg.sv =====
package oas_pkg;

  // speed or |perp| below 0.01: raw Q32.32 sum of squares below this
  localparam logic [63:0] SLOW_SQ       = 64'd429497;
  localparam logic [30:0] MAX_SPEED_RST = 31'd65536;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_LOAD,
    OP_VMX,
    OP_VMY,
    OP_VSUM,
    OP_SQ_START,
    OP_SQ_WAIT,
    OP_UX_START,
    OP_UX_WAIT,
    OP_UY_START,
    OP_UY_WAIT,
    OP_DIFF,
    OP_DOTX,
    OP_DOTY,
    OP_DOTSUM,
    OP_PROJ,
    OP_PMX,
    OP_PERPX,
    OP_PERPY,
    OP_SQX,
    OP_SQY,
    OP_SQLIM,
    OP_KEEP,
    OP_DIRB,
    OP_DIRV,
    OP_DMX,
    OP_DMY,
    OP_DSUM,
    OP_FMX,
    OP_FX_START,
    OP_FX_WAIT,
    OP_FMY,
    OP_FY_START,
    OP_FY_WAIT,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_VMX,
    ST_VMY,
    ST_VSUM,
    ST_VCHK,
    ST_VSQS,
    ST_VSQW,
    ST_UXS,
    ST_UXW,
    ST_UYS,
    ST_UYW,
    ST_OBS,
    ST_DIFF,
    ST_DOTX,
    ST_DOTY,
    ST_DOTSUM,
    ST_PROJ,
    ST_PMX,
    ST_PERPX,
    ST_PERPY,
    ST_BOXCHK,
    ST_SQX,
    ST_SQY,
    ST_SQLIM,
    ST_KEEP,
    ST_TAIL,
    ST_DIRB,
    ST_DIRV,
    ST_DMX,
    ST_DMY,
    ST_DSUM,
    ST_DCHK,
    ST_FSQS,
    ST_FSQW,
    ST_PMCHK,
    ST_FMX,
    ST_FXS,
    ST_FXW,
    ST_FMY,
    ST_FYS,
    ST_FYW,
    ST_EMIT0,
    ST_EMIT1
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   first;
    logic   computed;
  } dp_cmd_t;

  typedef struct packed {
    logic too_slow;
    logic found;
    logic dot_skip;
    logic box_skip;
    logic psq_small;
    logic pm_zero;
    logic unit_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/oas_divsqrt.sv =====
module oas_divsqrt
  import oas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start_div,
  input  logic        start_sqrt,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [63:0] res
);

  // one quotient bit or one root bit per cycle
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        mode_r, mode_nxt;   // 1: square root
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] work_r, work_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [32:0] dsh;
  logic [35:0] ssh, trial;

  always_comb begin
    dsh      = {rem_r[31:0], work_r[63]};
    ssh      = {rem_r, work_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start_div || start_sqrt) begin
      busy_nxt = 1'b1;
      mode_nxt = start_sqrt;
      cnt_nxt  = start_sqrt ? 7'd31 : 7'd63;
      work_nxt = num;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      if (mode_r) begin
        if (ssh >= trial) begin
          rem_nxt  = 34'(ssh - trial);
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = ssh[33:0];
          root_nxt = {root_r[30:0], 1'b0};
        end
        work_nxt = {work_r[61:0], 2'b00};
      end else begin
        if (dsh >= {1'b0, den}) begin
          rem_nxt  = {2'b00, 32'(dsh - {1'b0, den})};
          work_nxt = {work_r[62:0], 1'b1};
        end else begin
          rem_nxt  = {2'b00, dsh[31:0]};
          work_nxt = {work_r[62:0], 1'b0};
        end
      end
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign res  = mode_r ? {32'd0, root_r} : work_r;

endmodule

// ===== src/oas_dp.sv =====
module oas_dp
  import oas_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic signed [31:0] in_obstacle_x,
  input  logic signed [31:0] in_obstacle_y,
  input  logic [30:0]        in_obstacle_radius,
  input  logic signed [31:0] in_source_x,
  input  logic signed [31:0] in_source_y,
  input  logic signed [31:0] in_velocity_x,
  input  logic signed [31:0] in_velocity_y,
  input  logic [30:0]        in_source_radius,
  input  logic [30:0]        in_source_range,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               out_computed,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y
);

  logic [30:0]        ms_r;
  logic               too_slow_r, found_r, out_valid_r;
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, ux_r, uy_r;
  logic [30:0]        srad_r, rng_r, orad_r, p_r, best_r;
  logic signed [31:0] ob_x_r, ob_y_r, bpx_r, bpy_r, fx_r, fy_r;
  logic signed [32:0] dx_r, dy_r, dirx_r, diry_r;
  logic signed [34:0] px_r, py_r;
  logic [31:0]        rsum_r, pm_r;
  logic signed [67:0] prod_r, acc_r;
  logic [64:0]        a_r;
  logic               out_computed_r;
  logic signed [31:0] out_fx_r, out_fy_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] acc_sum, prod_sh;
  logic [34:0]        ax, ay;
  logic [32:0]        dmx, dmy;
  logic [31:0]        vmx;
  logic               u_start_div, u_start_sqrt, u_done;
  logic [63:0]        u_num, u_res;
  logic signed [65:0] qx, qy;
  logic               out_free, keep_ok;

  assign acc_sum = acc_r + prod_r;
  assign prod_sh = prod_r >>> 30;
  assign ax      = px_r[34] ? 35'(-px_r) : 35'(px_r);
  assign ay      = py_r[34] ? 35'(-py_r) : 35'(py_r);
  assign dmx     = dirx_r[32] ? 33'(-dirx_r) : 33'(dirx_r);
  assign dmy     = diry_r[32] ? 33'(-diry_r) : 33'(diry_r);
  assign out_free = !out_valid_r || !out_stall;
  assign keep_ok = !(a_r > {1'b0, prod_r[63:0]}) && (!found_r || (p_r < best_r));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_VMX:   begin mul_a = 34'(vel_x_r);  mul_b = 34'(vel_x_r); end
      OP_VMY:   begin mul_a = 34'(vel_y_r);  mul_b = 34'(vel_y_r); end
      OP_DOTX:  begin mul_a = 34'(dx_r);     mul_b = 34'(ux_r); end
      OP_DOTY:  begin mul_a = 34'(dy_r);     mul_b = 34'(uy_r); end
      OP_PMX:   begin mul_a = {3'b000, p_r}; mul_b = 34'(ux_r); end
      OP_PERPX: begin mul_a = {3'b000, p_r}; mul_b = 34'(uy_r); end
      OP_SQX:   begin mul_a = {2'b00, ax[31:0]}; mul_b = {2'b00, ax[31:0]}; end
      OP_SQY:   begin mul_a = {2'b00, ay[31:0]}; mul_b = {2'b00, ay[31:0]}; end
      OP_SQLIM: begin mul_a = {2'b00, rsum_r};   mul_b = {2'b00, rsum_r}; end
      OP_DMX:   begin mul_a = 34'(dirx_r);   mul_b = 34'(dirx_r); end
      OP_DMY:   begin mul_a = 34'(diry_r);   mul_b = 34'(diry_r); end
      OP_FMX:   begin mul_a = {1'b0, dmx};   mul_b = {3'b000, ms_r}; end
      OP_FMY:   begin mul_a = {1'b0, dmy};   mul_b = {3'b000, ms_r}; end
      default:  begin mul_a = '0;            mul_b = '0; end
    endcase
  end

  // shared divide / square-root unit
  always_comb begin
    vmx = 32'd0;
    u_num = acc_r[63:0];
    u_start_sqrt = (cmd.op == OP_SQ_START);
    u_start_div  = (cmd.op == OP_UX_START) || (cmd.op == OP_UY_START) ||
                   (cmd.op == OP_FX_START) || (cmd.op == OP_FY_START);
    if (cmd.op == OP_UX_START) begin
      vmx   = vel_x_r[31] ? 32'(-vel_x_r) : 32'(vel_x_r);
      u_num = {2'b00, vmx, 30'd0};
    end else if (cmd.op == OP_UY_START) begin
      vmx   = vel_y_r[31] ? 32'(-vel_y_r) : 32'(vel_y_r);
      u_num = {2'b00, vmx, 30'd0};
    end else if (cmd.op == OP_FX_START || cmd.op == OP_FY_START) begin
      u_num = prod_r[63:0];
    end
  end

  oas_divsqrt u_divsqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_div  (u_start_div),
    .start_sqrt (u_start_sqrt),
    .num        (u_num),
    .den        (pm_r),
    .done       (u_done),
    .res        (u_res)
  );

  assign qx = dirx_r[32] ? -$signed({2'b00, u_res}) : $signed({2'b00, u_res});
  assign qy = diry_r[32] ? -$signed({2'b00, u_res}) : $signed({2'b00, u_res});

  // control flags and the config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= MAX_SPEED_RST;
      too_slow_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) ms_r <= cfg_wdata;
      if (cmd.op == OP_LOAD && cmd.first) found_r <= 1'b0;
      if (cmd.op == OP_VSUM) too_slow_r <= (acc_sum < $signed({4'd0, SLOW_SQ}));
      if (cmd.op == OP_KEEP && keep_ok) found_r <= 1'b1;
      if (cmd.op == OP_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        ob_x_r <= in_obstacle_x;
        ob_y_r <= in_obstacle_y;
        orad_r <= in_obstacle_radius;
        if (cmd.first) begin
          pos_x_r <= in_source_x;
          pos_y_r <= in_source_y;
          vel_x_r <= in_velocity_x;
          vel_y_r <= in_velocity_y;
          srad_r  <= in_source_radius;
          rng_r   <= in_source_range;
          best_r  <= '0;
          bpx_r   <= '0;
          bpy_r   <= '0;
        end
      end
      OP_VMY, OP_DOTY, OP_DMY: acc_r <= prod_r;
      OP_VSUM, OP_DOTSUM, OP_DSUM: acc_r <= acc_sum;
      OP_SQ_WAIT: if (u_done) pm_r <= u_res[31:0];
      OP_UX_WAIT: if (u_done) ux_r <= vel_x_r[31] ? 32'(-u_res[31:0]) : u_res[31:0];
      OP_UY_WAIT: if (u_done) uy_r <= vel_y_r[31] ? 32'(-u_res[31:0]) : u_res[31:0];
      OP_DIFF: begin
        dx_r <= 33'(ob_x_r) - 33'(pos_x_r);
        dy_r <= 33'(ob_y_r) - 33'(pos_y_r);
      end
      OP_PROJ:  p_r  <= acc_r[60:30];
      OP_PERPX: px_r <= prod_sh[34:0] - 35'(dx_r);
      OP_PERPY: begin
        py_r   <= prod_sh[34:0] - 35'(dy_r);
        rsum_r <= {1'b0, srad_r} + {1'b0, orad_r};
      end
      OP_SQY:   a_r <= {1'b0, prod_r[63:0]};
      OP_SQLIM: a_r <= a_r + {1'b0, prod_r[63:0]};
      OP_KEEP: if (keep_ok) begin
        best_r <= p_r;
        bpx_r  <= sat32(66'(px_r));
        bpy_r  <= sat32(66'(py_r));
      end
      OP_DIRB: begin
        dirx_r <= 33'(bpx_r);
        diry_r <= 33'(bpy_r);
      end
      OP_DIRV: begin
        dirx_r <= 33'(vel_y_r);
        diry_r <= -33'(vel_x_r);
      end
      OP_FX_WAIT: if (u_done) fx_r <= sat32(qx - 66'(vel_x_r));
      OP_FY_WAIT: if (u_done) fy_r <= sat32(qy - 66'(vel_y_r));
      OP_EMIT: if (out_free) begin
        out_computed_r <= cmd.computed;
        out_fx_r       <= cmd.computed ? fx_r : 32'sd0;
        out_fy_r       <= cmd.computed ? fy_r : 32'sd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.too_slow  = too_slow_r;
    stat.found     = found_r;
    stat.dot_skip  = acc_r[67] || (acc_r > $signed({7'd0, rng_r, 30'd0}));
    stat.box_skip  = (ax > {3'b000, rsum_r}) || (ay > {3'b000, rsum_r});
    stat.psq_small = acc_r < $signed({4'd0, SLOW_SQ});
    stat.pm_zero   = (pm_r == 32'd0);
    stat.unit_done = u_done;
    stat.out_free  = out_free;
  end

  assign out_valid    = out_valid_r;
  assign out_computed = out_computed_r;
  assign out_force_x  = out_fx_r;
  assign out_force_y  = out_fy_r;

endmodule

// ===== src/oas_ctrl.sv =====
module oas_ctrl
  import oas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_has_obstacle,
  input  logic     in_last_obstacle,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic in_query_r, in_query_nxt;
  logic has_r, has_nxt;
  logic last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_query_r <= 1'b0;
      has_r      <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_query_r <= in_query_nxt;
      has_r      <= has_nxt;
      last_r     <= last_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_query_nxt = in_query_r;
    has_nxt      = has_r;
    last_nxt     = last_r;
    cmd.op       = OP_NONE;
    cmd.first    = 1'b0;
    cmd.computed = 1'b0;
    in_stall     = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        cmd.op       = OP_LOAD;
        cmd.first    = !in_query_r;
        has_nxt      = in_has_obstacle;
        last_nxt     = in_last_obstacle;
        in_query_nxt = 1'b1;
        state_nxt    = in_query_r ? ST_OBS : ST_VMX;
      end
      ST_VMX:  begin cmd.op = OP_VMX;  state_nxt = ST_VMY; end
      ST_VMY:  begin cmd.op = OP_VMY;  state_nxt = ST_VSUM; end
      ST_VSUM: begin cmd.op = OP_VSUM; state_nxt = ST_VCHK; end
      ST_VCHK: state_nxt = stat.too_slow ? ST_OBS : ST_VSQS;
      ST_VSQS: begin cmd.op = OP_SQ_START; state_nxt = ST_VSQW; end
      ST_VSQW: begin
        cmd.op = OP_SQ_WAIT;
        if (stat.unit_done) state_nxt = ST_UXS;
      end
      ST_UXS: begin cmd.op = OP_UX_START; state_nxt = ST_UXW; end
      ST_UXW: begin
        cmd.op = OP_UX_WAIT;
        if (stat.unit_done) state_nxt = ST_UYS;
      end
      ST_UYS: begin cmd.op = OP_UY_START; state_nxt = ST_UYW; end
      ST_UYW: begin
        cmd.op = OP_UY_WAIT;
        if (stat.unit_done) state_nxt = ST_OBS;
      end
      ST_OBS:    state_nxt = (has_r && !stat.too_slow) ? ST_DIFF : ST_TAIL;
      ST_DIFF:   begin cmd.op = OP_DIFF;   state_nxt = ST_DOTX; end
      ST_DOTX:   begin cmd.op = OP_DOTX;   state_nxt = ST_DOTY; end
      ST_DOTY:   begin cmd.op = OP_DOTY;   state_nxt = ST_DOTSUM; end
      ST_DOTSUM: begin cmd.op = OP_DOTSUM; state_nxt = ST_PROJ; end
      ST_PROJ: begin
        cmd.op    = OP_PROJ;
        state_nxt = stat.dot_skip ? ST_TAIL : ST_PMX;
      end
      ST_PMX:    begin cmd.op = OP_PMX;   state_nxt = ST_PERPX; end
      ST_PERPX:  begin cmd.op = OP_PERPX; state_nxt = ST_PERPY; end
      ST_PERPY:  begin cmd.op = OP_PERPY; state_nxt = ST_BOXCHK; end
      ST_BOXCHK: state_nxt = stat.box_skip ? ST_TAIL : ST_SQX;
      ST_SQX:    begin cmd.op = OP_SQX;   state_nxt = ST_SQY; end
      ST_SQY:    begin cmd.op = OP_SQY;   state_nxt = ST_SQLIM; end
      ST_SQLIM:  begin cmd.op = OP_SQLIM; state_nxt = ST_KEEP; end
      ST_KEEP:   begin cmd.op = OP_KEEP;  state_nxt = ST_TAIL; end
      ST_TAIL: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else begin
          in_query_nxt = 1'b0;
          state_nxt    = (!stat.too_slow && stat.found) ? ST_DIRB : ST_EMIT0;
        end
      end
      ST_DIRB: begin cmd.op = OP_DIRB; state_nxt = ST_DMX; end
      ST_DIRV: begin cmd.op = OP_DIRV; state_nxt = ST_DMX; end
      ST_DMX:  begin cmd.op = OP_DMX;  state_nxt = ST_DMY; end
      ST_DMY:  begin cmd.op = OP_DMY;  state_nxt = ST_DSUM; end
      ST_DSUM: begin cmd.op = OP_DSUM; state_nxt = ST_DCHK; end
      ST_DCHK: state_nxt = stat.psq_small ? ST_DIRV : ST_FSQS;
      ST_FSQS: begin cmd.op = OP_SQ_START; state_nxt = ST_FSQW; end
      ST_FSQW: begin
        cmd.op = OP_SQ_WAIT;
        if (stat.unit_done) state_nxt = ST_PMCHK;
      end
      ST_PMCHK: state_nxt = stat.pm_zero ? ST_EMIT0 : ST_FMX;
      ST_FMX: begin cmd.op = OP_FMX; state_nxt = ST_FXS; end
      ST_FXS: begin cmd.op = OP_FX_START; state_nxt = ST_FXW; end
      ST_FXW: begin
        cmd.op = OP_FX_WAIT;
        if (stat.unit_done) state_nxt = ST_FMY;
      end
      ST_FMY: begin cmd.op = OP_FMY; state_nxt = ST_FYS; end
      ST_FYS: begin cmd.op = OP_FY_START; state_nxt = ST_FYW; end
      ST_FYW: begin
        cmd.op = OP_FY_WAIT;
        if (stat.unit_done) state_nxt = ST_EMIT1;
      end
      ST_EMIT0: begin
        cmd.op = OP_EMIT;
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_EMIT1: begin
        cmd.op       = OP_EMIT;
        cmd.computed = 1'b1;
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== src/obstacle_avoidance_steer.sv =====
// Obstacle avoidance steering, one obstacle request at a time.
// The first request of a query also finds the unit velocity (sum of squares, 32-step root,
// two 64-step divides); root and divides are skipped when the agent is too slow.
// The last request then finds the force (32-step root, two 64-step divides), first falling
// back to the velocity's perpendicular when the nearest hit lies dead ahead.
// One multiplier and the shared divide/root unit serve all steps; a new request waits for idle.
// Synchronous active-low reset: idle, no open query, max_speed = 1.0, no result pending.
module obstacle_avoidance_steer
  import oas_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // config: max_speed, unsigned Q16.16
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  // obstacle requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_obstacle_x,
  input  logic signed [31:0] in_obstacle_y,
  input  logic [30:0]        in_obstacle_radius,
  input  logic               in_has_obstacle,
  input  logic signed [31:0] in_source_x,
  input  logic signed [31:0] in_source_y,
  input  logic signed [31:0] in_velocity_x,
  input  logic signed [31:0] in_velocity_y,
  input  logic [30:0]        in_source_radius,
  input  logic [30:0]        in_source_range,
  input  logic               in_last_obstacle,
  // steering results, one per query
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_computed,
  output logic signed [31:0] out_force_x,
  output logic signed [31:0] out_force_y
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller: walks each request through the datapath, at most one op per state.
  // It holds the open-query flag and the has/last bits of the current request.
  oas_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_has_obstacle  (in_has_obstacle),
    .in_last_obstacle (in_last_obstacle),
    .in_stall         (in_stall),
    .stat             (stat),
    .cmd              (cmd)
  );

  // Datapath: agent registers, one registered 34x34 multiplier, the shared
  // iterative divide/root unit, nearest-hit tracking and the output register.
  // The output register lets a finished result wait while new requests enter.
  oas_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_obstacle_x      (in_obstacle_x),
    .in_obstacle_y      (in_obstacle_y),
    .in_obstacle_radius (in_obstacle_radius),
    .in_source_x        (in_source_x),
    .in_source_y        (in_source_y),
    .in_velocity_x      (in_velocity_x),
    .in_velocity_y      (in_velocity_y),
    .in_source_radius   (in_source_radius),
    .in_source_range    (in_source_range),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_computed       (out_computed),
    .out_force_x        (out_force_x),
    .out_force_y        (out_force_y)
  );

`ifndef SYNTHESIS
  // an accepted request always takes the controller out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // a result only shows up right after an emit op
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == OP_EMIT))
    else $error("result without emit");

  // no force without a hit
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_computed |-> out_force_x == 32'sd0 && out_force_y == 32'sd0)
    else $error("nonzero force on empty result");
`endif

endmodule
